@@ hw/rtl/upsample2_midpoint_interpolator_assert.svh @@
// assertion macros for the midpoint interpolator
`ifndef UPSAMPLE2_MIDPOINT_INTERPOLATOR_ASSERT_SVH
`define UPSAMPLE2_MIDPOINT_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define UMP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("upsample2_midpoint_interpolator: check failed");

// next-cycle implication
`define UMP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("upsample2_midpoint_interpolator: check failed");

`endif

@@ hw/rtl/ump_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ump_pkg;

   localparam int SAMPLE_WIDTH = 32;
   localparam int MAX_TAPS     = 8;

   localparam int TAP_EVEN  = (MAX_TAPS / 2) * 2;
   localparam int TAP_LIM   = (TAP_EVEN < 2) ? 2 : TAP_EVEN;
   localparam int NUM_PAIRS = TAP_LIM / 2;
   localparam int WIN_AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

   localparam int COEF_W     = 12;
   localparam int FRAC_BITS  = 11;
   localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
   localparam int PAIR_W     = SAMPLE_WIDTH + 1;
   localparam int PROD_W     = PAIR_W + COEF_W;
   localparam int ACC_W      = PROD_W + 2;

   localparam int FILL_W      = 4;
   localparam int MAX_RESULTS = 3;
   localparam int CNT_W       = 2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 2;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [PAIR_W-1:0]       pair_type;
   typedef logic signed [PROD_W-1:0]       prod_type;
   typedef logic signed [ACC_W-1:0]        acc_type;
   typedef logic signed [COEF_W-1:0]       coef_type;
   typedef logic [1:0]                     order_type;
   typedef logic [FILL_W-1:0]              fill_type;
   typedef logic [WIN_AW-1:0]              win_idx_type;
   typedef logic [CNT_W-1:0]               cnt_type;
   typedef logic [CSR_IDX_W-1:0]           csr_idx_type;
   typedef logic [CSR_DATA_W-1:0]          csr_data_type;

   localparam fill_type  FILL_MAX  = '1;
   localparam order_type ORDER_MAX = order_type'(NUM_PAIRS - 1);

   localparam csr_idx_type CSR_ORDER_SEL  = 2'd0;
   localparam csr_idx_type CSR_SKIP_FIRST = 2'd1;
   localparam csr_idx_type CSR_SKIP_LAST  = 2'd2;

   typedef struct packed {
      order_type order_sel;
      logic      skip_first;
      logic      skip_last;
   } cfg_type;

   typedef struct packed {
      logic emit_centre;
      logic emit_mid;
      logic emit_final;
      logic row_end;
   } ctl_type;

   // pair weights in units of 1/2048, one row per filter order
   localparam coef_type COEF_TAB [0:3][0:3] = '{
      '{12'sd1024,  12'sd0,    12'sd0,  12'sd0},
      '{12'sd1152, -12'sd128,  12'sd0,  12'sd0},
      '{12'sd1200, -12'sd200,  12'sd24, 12'sd0},
      '{12'sd1225, -12'sd245,  12'sd49, -12'sd5}
   };

endpackage

`default_nettype wire

@@ hw/rtl/ump_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ump_req_if import ump_pkg::*;;
   logic       valid;
   logic       ready;
   sample_type sample;
   logic       row_end;

   modport source (output valid, output sample, output row_end, input ready);
   modport sink   (input valid, input sample, input row_end, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ump_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ump_rsp_if import ump_pkg::*;;
   logic       valid;
   logic       ready;
   sample_type value;
   logic       is_midpoint;
   logic       row_done;
   logic       run_last;

   modport source (output valid, output value, output is_midpoint, output row_done,
                   output run_last, input ready);
   modport sink   (input valid, input value, input is_midpoint, input row_done,
                   input run_last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ump_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ump_front import ump_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   ump_req_if.sink    req,
   output logic       s1_valid,
   input  logic       s1_ready,
   output pair_type   s1_pair [NUM_PAIRS],
   output order_type  s1_order,
   output sample_type s1_centre,
   output sample_type s1_final,
   output ctl_type    s1_ctl
);

   sample_type  window_ff [MAX_TAPS];
   sample_type  window_in [MAX_TAPS];
   fill_type    fill_ff, fill_in;
   logic        valid_ff, valid_in;
   pair_type    pair_ff [NUM_PAIRS];
   pair_type    pair_in [NUM_PAIRS];
   order_type   order_ff, order_in;
   sample_type  centre_ff, centre_in;
   sample_type  final_ff, final_in;
   ctl_type     ctl_ff, ctl_in;

   sample_type  win_new [MAX_TAPS];
   order_type   eff_order;
   win_idx_type half;
   fill_type    taps, fill_new;
   logic [FILL_W:0] fill_nx, taps_x;
   win_idx_type hi_idx [NUM_PAIRS];
   win_idx_type lo_idx [NUM_PAIRS];
   logic        accept;

   assign req.ready = !valid_ff || s1_ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      eff_order = (cfg.order_sel > ORDER_MAX) ? ORDER_MAX : cfg.order_sel;
      half      = win_idx_type'(eff_order) + win_idx_type'(1);
      taps      = (fill_type'(eff_order) + fill_type'(1)) << 1;
      fill_new  = (fill_ff == FILL_MAX) ? fill_ff : fill_ff + fill_type'(1);
      fill_nx   = {1'b0, fill_new} + (FILL_W+1)'(1);
      taps_x    = {1'b0, taps};

      win_new[0] = req.sample;
      for (int d = 1; d < MAX_TAPS; d++) begin
         win_new[d] = window_ff[d-1];
      end

      // pairs beyond the active filter stay zero
      for (int p = 0; p < NUM_PAIRS; p++) begin
         hi_idx[p] = half + win_idx_type'(p);
         lo_idx[p] = half - win_idx_type'(1) - win_idx_type'(p);
         if (win_idx_type'(p) < half) begin
            pair_in[p] = pair_type'(win_new[hi_idx[p]]) + pair_type'(win_new[lo_idx[p]]);
         end else begin
            pair_in[p] = '0;
         end
      end

      ctl_in.emit_mid    = fill_new >= taps;
      ctl_in.emit_centre = ctl_in.emit_mid && !(fill_new == taps && cfg.skip_first);
      ctl_in.emit_final  = req.row_end && cfg.skip_last && (fill_nx >= taps_x) &&
                           !(fill_nx == taps_x && cfg.skip_first);
      ctl_in.row_end     = req.row_end;

      order_in  = eff_order;
      centre_in = win_new[half];
      final_in  = win_new[half - win_idx_type'(1)];

      window_in = window_ff;
      fill_in   = fill_ff;
      valid_in  = valid_ff;
      if (req.ready) begin
         valid_in = accept;
      end
      if (accept) begin
         window_in = win_new;
         fill_in   = req.row_end ? '0 : fill_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < MAX_TAPS; d++) begin
            window_ff[d] <= '0;
         end
         fill_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         window_ff <= window_in;
         fill_ff   <= fill_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pair_ff   <= pair_in;
         order_ff  <= order_in;
         centre_ff <= centre_in;
         final_ff  <= final_in;
         ctl_ff    <= ctl_in;
      end
   end

   assign s1_valid  = valid_ff;
   assign s1_pair   = pair_ff;
   assign s1_order  = order_ff;
   assign s1_centre = centre_ff;
   assign s1_final  = final_ff;
   assign s1_ctl    = ctl_ff;

endmodule

`default_nettype wire

@@ hw/rtl/ump_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ump_mac import ump_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       s1_valid,
   output logic       s1_ready,
   input  pair_type   s1_pair [NUM_PAIRS],
   input  order_type  s1_order,
   input  sample_type s1_centre,
   input  sample_type s1_final,
   input  ctl_type    s1_ctl,
   output logic       s2_valid,
   input  logic       s2_ready,
   output prod_type   s2_prod [NUM_PAIRS],
   output sample_type s2_centre,
   output sample_type s2_final,
   output ctl_type    s2_ctl
);

   logic       valid_ff, valid_in;
   prod_type   prod_ff [NUM_PAIRS];
   prod_type   prod_in [NUM_PAIRS];
   sample_type centre_ff, final_ff;
   ctl_type    ctl_ff;
   logic       load;

   assign s1_ready = !valid_ff || s2_ready;
   assign load     = s1_valid && s1_ready;

   always_comb begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
         prod_in[p] = prod_type'(s1_pair[p]) * prod_type'(COEF_TAB[s1_order][p]);
      end
      valid_in = s1_ready ? s1_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff   <= prod_in;
         centre_ff <= s1_centre;
         final_ff  <= s1_final;
         ctl_ff    <= s1_ctl;
      end
   end

   assign s2_valid  = valid_ff;
   assign s2_prod   = prod_ff;
   assign s2_centre = centre_ff;
   assign s2_final  = final_ff;
   assign s2_ctl    = ctl_ff;

endmodule

`default_nettype wire

@@ hw/rtl/ump_out.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ump_out import ump_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       s2_valid,
   output logic       s2_ready,
   input  prod_type   s2_prod [NUM_PAIRS],
   input  sample_type s2_centre,
   input  sample_type s2_final,
   input  ctl_type    s2_ctl,
   ump_rsp_if.source  rsp
);

   localparam acc_type SAT_MAX = acc_type'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
   localparam acc_type SAT_MIN = -SAT_MAX - acc_type'(1);

   logic       grp_valid_ff, grp_valid_in;
   cnt_type    ptr_ff, ptr_in;
   cnt_type    cnt_ff;
   logic       end_ff;
   sample_type val_ff [MAX_RESULTS];
   logic       mid_ff [MAX_RESULTS];

   acc_type    acc, rnd, shifted;
   sample_type mid_val;
   sample_type ent_val [MAX_RESULTS];
   logic       ent_mid [MAX_RESULTS];
   cnt_type    ent_n;
   logic       take, last, load;

   assign take     = rsp.valid && rsp.ready;
   assign last     = ptr_ff == cnt_ff - cnt_type'(1);
   assign s2_ready = !grp_valid_ff || (take && last);
   assign load     = s2_valid && s2_ready;

   always_comb begin
      acc = '0;
      for (int p = 0; p < NUM_PAIRS; p++) begin
         acc = acc + acc_type'(s2_prod[p]);
      end
      rnd     = acc + acc_type'(ROUND_HALF);
      shifted = rnd >>> FRAC_BITS;
      if (shifted > SAT_MAX) begin
         mid_val = SAT_MAX[SAMPLE_WIDTH-1:0];
      end else if (shifted < SAT_MIN) begin
         mid_val = SAT_MIN[SAMPLE_WIDTH-1:0];
      end else begin
         mid_val = shifted[SAMPLE_WIDTH-1:0];
      end

      // pack the words of this item in output order
      for (int i = 0; i < MAX_RESULTS; i++) begin
         ent_val[i] = '0;
         ent_mid[i] = 1'b0;
      end
      ent_n = '0;
      if (s2_ctl.emit_centre) begin
         ent_val[ent_n] = s2_centre;
         ent_mid[ent_n] = 1'b0;
         ent_n          = ent_n + cnt_type'(1);
      end
      if (s2_ctl.emit_mid) begin
         ent_val[ent_n] = mid_val;
         ent_mid[ent_n] = 1'b1;
         ent_n          = ent_n + cnt_type'(1);
      end
      if (s2_ctl.emit_final) begin
         ent_val[ent_n] = s2_final;
         ent_mid[ent_n] = 1'b0;
         ent_n          = ent_n + cnt_type'(1);
      end

      grp_valid_in = grp_valid_ff;
      ptr_in       = ptr_ff;
      if (s2_ready) begin
         grp_valid_in = s2_valid && (ent_n != '0);
         ptr_in       = '0;
      end else if (take) begin
         ptr_in = ptr_ff + cnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_valid_ff <= 1'b0;
         ptr_ff       <= '0;
      end else begin
         grp_valid_ff <= grp_valid_in;
         ptr_ff       <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         val_ff <= ent_val;
         mid_ff <= ent_mid;
         cnt_ff <= ent_n;
         end_ff <= s2_ctl.row_end;
      end
   end

   assign rsp.valid       = grp_valid_ff;
   assign rsp.value       = val_ff[ptr_ff];
   assign rsp.is_midpoint = mid_ff[ptr_ff];
   assign rsp.run_last    = last;
   assign rsp.row_done    = last && end_ff;

endmodule

`default_nettype wire

@@ hw/rtl/upsample2_midpoint_interpolator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Interpolates a row of signed samples by two with a symmetric Lagrange midpoint
// filter of 2, 4, 6 or 8 taps. Each accepted word yields up to three result words
// (center sample, midpoint, and the final center of a row when skip_last is set),
// sent one per cycle on rsp_if while it is ready, and the rate is set by that single
// result port; req_if takes a new word in any cycle in which the three-stage pipe
// (window, multiply, round and emit) can move. The first result word of an item is
// registered in the window, multiply and output stages in turn before it is valid.
// Reset clears the tap window, the row count and the configuration; csr writes
// belong in idle periods only.

`include "upsample2_midpoint_interpolator_assert.svh"

module upsample2_midpoint_interpolator import ump_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   ump_req_if.sink      req_if,
   ump_rsp_if.source    rsp_if,
   input  logic         csr_we,
   input  csr_idx_type  csr_index,
   input  csr_data_type csr_wdata
);

   cfg_type    cfg_ff, cfg_in;

   logic       s1_valid, s1_ready;
   pair_type   s1_pair [NUM_PAIRS];
   order_type  s1_order;
   sample_type s1_centre, s1_final;
   ctl_type    s1_ctl;

   logic       s2_valid, s2_ready;
   prod_type   s2_prod [NUM_PAIRS];
   sample_type s2_centre, s2_final;
   ctl_type    s2_ctl;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ORDER_SEL:  cfg_in.order_sel  = csr_wdata[1:0];
            CSR_SKIP_FIRST: cfg_in.skip_first = csr_wdata[0];
            CSR_SKIP_LAST:  cfg_in.skip_last  = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ump_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req       (req_if),
      .s1_valid  (s1_valid),
      .s1_ready  (s1_ready),
      .s1_pair   (s1_pair),
      .s1_order  (s1_order),
      .s1_centre (s1_centre),
      .s1_final  (s1_final),
      .s1_ctl    (s1_ctl)
   );

   ump_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid),
      .s1_ready  (s1_ready),
      .s1_pair   (s1_pair),
      .s1_order  (s1_order),
      .s1_centre (s1_centre),
      .s1_final  (s1_final),
      .s1_ctl    (s1_ctl),
      .s2_valid  (s2_valid),
      .s2_ready  (s2_ready),
      .s2_prod   (s2_prod),
      .s2_centre (s2_centre),
      .s2_final  (s2_final),
      .s2_ctl    (s2_ctl)
   );

   ump_out u_out (
      .clock     (clock),
      .reset     (reset),
      .s2_valid  (s2_valid),
      .s2_ready  (s2_ready),
      .s2_prod   (s2_prod),
      .s2_centre (s2_centre),
      .s2_final  (s2_final),
      .s2_ctl    (s2_ctl),
      .rsp       (rsp_if)
   );

   `UMP_ASSERT_NOW(a_row_done_is_last, clock, reset,
      rsp_if.valid && rsp_if.row_done, rsp_if.run_last)
   `UMP_ASSERT_NEXT(a_group_continues, clock, reset,
      rsp_if.valid && rsp_if.ready && !rsp_if.run_last, rsp_if.valid)
   `UMP_ASSERT_NOW(a_no_overrun, clock, reset,
      req_if.valid && req_if.ready, !s1_valid || s1_ready)

endmodule

`default_nettype wire
